// ----- rtl/counting_semaphore_table_unit_macros.svh -----
// Assertion macros for the counting semaphore table unit
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CSEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/csem_pkg.sv -----
// Package: types, codes and defaults of the counting semaphore table unit
`default_nettype none
package csem_pkg;

  localparam int NUM_SEMS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int PID_BITS_DEF    = 8;
  localparam int CNT_W           = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_OPEN  = 3'd1;
  localparam logic [2:0] REQ_CLOSE = 3'd2;
  localparam logic [2:0] REQ_WAIT  = 3'd3;
  localparam logic [2:0] REQ_POST  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_BLOCK = 2'd1;
  localparam logic [1:0] ACT_WAKE  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  sem_index;
    logic [15:0] initial_count;
    logic [7:0]  caller_pid;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] action;
    logic [7:0] woken_pid;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/counting_semaphore_table_unit.sv -----
// Top level: counting semaphore table with per-entry FIFO wait queues
//
// Input channel in_valid/in_ready/in_data carries one request item (init,
// open, close, wait or post on one table entry). Result channel
// out_valid/out_ready/out_data returns one result item per request, or one
// per woken waiter for a close; the final result of a request has last set.
// One request is handled at a time: in_ready is high only while idle.
// A request without a queue pop reads its table entry at the accepting
// edge, then evaluates into the output register; a post or close that pops
// a waiter first reads the waiter store and then pops it into the output
// register. A close with waiters repeats that pop loop, one wake per pass
// through the single waiter store read port.
// A stalled receiver holds the result in the output register and the
// block waits; nothing is lost or repeated.
// Reset clears all entry valid bits and returns to idle; count, queue and
// waiter stores are written by init and wait before they are read.
`default_nettype none
module counting_semaphore_table_unit #(
  parameter int NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = csem_pkg::PID_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  csem_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output csem_pkg::out_item_t out_data
);
  import csem_pkg::*;

  localparam int SEM_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WADDR_W = $clog2(NUM_SEMS * QUEUE_DEPTH);
  localparam int TW      = CNT_W + HEAD_W + FILL_W;
  localparam logic [FILL_W-1:0] QD_FILL = FILL_W'(QUEUE_DEPTH);
  localparam logic [HEAD_W-1:0] QD_LAST = HEAD_W'(QUEUE_DEPTH - 1);

  state_t              state_r, state_nxt;
  logic [NUM_SEMS-1:0] valid_r, valid_nxt;
  logic                more_r, more_nxt;

  logic [2:0]          req_r;
  logic [SEM_W-1:0]    sidx_r;
  logic                in_tbl_r;
  logic [CNT_W-1:0]    init_r;
  logic [PID_BITS-1:0] pid_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [HEAD_W-1:0]   head_r, head_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  out_item_t           out_r, out_nxt;

  logic [TW-1:0]       tbl_mem [NUM_SEMS];
  logic [TW-1:0]       tbl_q;
  logic [TW-1:0]       tw_data;
  logic                tw_en;
  logic [SEM_W-1:0]    tbl_ra;

  logic [PID_BITS-1:0] wmem [NUM_SEMS*QUEUE_DEPTH];
  logic [PID_BITS-1:0] wq;
  logic                ww_en;
  logic [WADDR_W-1:0]  waddr_rd, waddr_wr;

  logic                in_acc;
  logic [SEM_W+3:0]    idx_ext;
  logic [SEM_W-1:0]    in_s;
  logic                in_tbl;
  logic [PID_BITS+7:0] pid_ext;
  logic [PID_BITS+7:0] wk_ext;

  logic [CNT_W-1:0]    cnt_q;
  logic [HEAD_W-1:0]   head_q;
  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W:0]     slot_sum, slot_mod;
  logic [HEAD_W-1:0]   slot;
  logic [HEAD_W-1:0]   head_adv;
  logic [FILL_W-1:0]   fill_dec;
  logic                present;

  assign in_acc   = in_valid && in_ready;
  assign idx_ext  = {{SEM_W{1'b0}}, in_data.sem_index};
  assign in_s     = idx_ext[SEM_W-1:0];
  assign in_tbl   = 32'(in_data.sem_index) < NUM_SEMS;
  assign pid_ext  = {{PID_BITS{1'b0}}, in_data.caller_pid};
  assign wk_ext   = {8'd0, wq};

  assign cnt_q    = tbl_q[TW-1 -: CNT_W];
  assign head_q   = tbl_q[FILL_W +: HEAD_W];
  assign fill_q   = tbl_q[FILL_W-1:0];
  assign slot_sum = {1'b0, fill_q} + (FILL_W+1)'(head_q);
  assign slot_mod = (slot_sum >= (FILL_W+1)'(QUEUE_DEPTH)) ?
                    slot_sum - (FILL_W+1)'(QUEUE_DEPTH) : slot_sum;
  assign slot     = slot_mod[HEAD_W-1:0];
  assign head_adv = (head_r == QD_LAST) ? '0 : head_r + HEAD_W'(1);
  assign fill_dec = fill_r - FILL_W'(1);
  assign present  = in_tbl_r && valid_r[sidx_r];

  assign tbl_ra   = (state_r == S_IDLE) ? in_s : sidx_r;
  assign waddr_rd = WADDR_W'(int'(sidx_r) * QUEUE_DEPTH + int'(head_r));
  assign waddr_wr = WADDR_W'(int'(sidx_r) * QUEUE_DEPTH + int'(slot));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      more_r  <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_data.req_type;
      sidx_r   <= in_s;
      in_tbl_r <= in_tbl;
      init_r   <= in_data.initial_count;
      pid_r    <= pid_ext[PID_BITS-1:0];
    end
    cnt_r  <= cnt_nxt;
    head_r <= head_nxt;
    fill_r <= fill_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tbl_mem[sidx_r] <= tw_data;
    end
    tbl_q <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (ww_en) begin
      wmem[waddr_wr] <= pid_r;
    end
    wq <= wmem[waddr_rd];
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    more_nxt  = more_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    out_nxt   = out_r;
    tw_en     = 1'b0;
    tw_data   = {cnt_r, head_r, fill_r};
    ww_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cnt_nxt           = cnt_q;
        head_nxt          = head_q;
        fill_nxt          = fill_q;
        more_nxt          = 1'b0;
        out_nxt.status    = ST_FAIL;
        out_nxt.action    = ACT_NONE;
        out_nxt.woken_pid = '0;
        out_nxt.last      = 1'b1;
        state_nxt         = S_OUT;
        case (req_r)
          REQ_INIT: begin
            if (in_tbl_r && !present) begin
              valid_nxt[sidx_r] = 1'b1;
              tw_en             = 1'b1;
              tw_data           = {init_r, {HEAD_W{1'b0}}, {FILL_W{1'b0}}};
              out_nxt.status    = ST_OK;
            end
          end
          REQ_OPEN: begin
            if (present) begin
              out_nxt.status = ST_OK;
            end
          end
          REQ_CLOSE: begin
            if (present) begin
              out_nxt.status = ST_OK;
              if (fill_q == '0) begin
                valid_nxt[sidx_r] = 1'b0;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
          end
          REQ_WAIT: begin
            if (present) begin
              if (cnt_q != '0) begin
                tw_en          = 1'b1;
                tw_data        = {cnt_q - CNT_W'(1), head_q, fill_q};
                out_nxt.status = ST_OK;
              end else if (fill_q == QD_FILL) begin
                out_nxt.status = ST_FULL;
              end else begin
                ww_en          = 1'b1;
                tw_en          = 1'b1;
                tw_data        = {cnt_q, head_q, fill_q + FILL_W'(1)};
                out_nxt.status = ST_OK;
                out_nxt.action = ACT_BLOCK;
              end
            end
          end
          REQ_POST: begin
            if (present) begin
              out_nxt.status = ST_OK;
              if (fill_q != '0) begin
                state_nxt = S_POP_RD;
              end else begin
                tw_en   = 1'b1;
                tw_data = {(cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1),
                           head_q, fill_q};
              end
            end
          end
          default: begin
            out_nxt.status = ST_FAIL;
          end
        endcase
      end
      S_POP_RD: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        head_nxt          = head_adv;
        fill_nxt          = fill_dec;
        tw_en             = 1'b1;
        tw_data           = {cnt_r, head_adv, fill_dec};
        out_nxt.status    = ST_OK;
        out_nxt.action    = ACT_WAKE;
        out_nxt.woken_pid = wk_ext[7:0];
        out_nxt.last      = (req_r != REQ_CLOSE) || (fill_dec == '0);
        more_nxt          = (req_r == REQ_CLOSE) && (fill_dec != '0);
        if ((req_r == REQ_CLOSE) && (fill_dec == '0)) begin
          valid_nxt[sidx_r] = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = more_r ? S_POP_RD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/csem_checker.sv -----
// Port-level checker for the counting semaphore table unit, with its bind
`default_nettype none
`include "counting_semaphore_table_unit_macros.svh"
module csem_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input csem_pkg::in_item_t  in_data,
  input wire                 out_valid,
  input wire                 out_ready,
  input csem_pkg::out_item_t out_data
);
  import csem_pkg::*;

  logic unused_in;
  assign unused_in = ^in_data;

  `CSEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `CSEM_ASSERT_NOW(a_one_at_a_time, in_ready, !out_valid, "ready while a result is pending")
  `CSEM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
  `CSEM_ASSERT_NOW(a_wake_ok, out_valid && (out_data.action == ACT_WAKE), out_data.status == ST_OK, "wake with bad status")
  `CSEM_ASSERT_NOW(a_block_last, out_valid && (out_data.action == ACT_BLOCK), out_data.last && (out_data.woken_pid == '0), "block result malformed")

endmodule

bind counting_semaphore_table_unit csem_checker u_csem_checker (.*);
`default_nettype wire
